[sv/utf8sd_pkg.sv]
package utf8sd_pkg;

    localparam logic [15:0] CAPACITY_RESET = 16'd1024;

    // Per-string decoder state.
    typedef struct packed {
        logic [7:0]  lead_byte;
        logic [30:0] accum_value;
        logic [2:0]  seq_position;
        logic [15:0] units_written;
        logic        halted;
    } dec_state_t;

    // One result item.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        decode_error;
        logic        string_end;
        logic [15:0] unit_count;
    } dec_result_t;

    // Sequence length selected by a lead byte; zero for an invalid lead.
    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] len;
        priority casez (b)
            8'b0???????: len = 3'd1;
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            8'b111110??: len = 3'd5;
            8'b1111110?: len = 3'd6;
            default:     len = 3'd0;
        endcase
        return len;
    endfunction

    // Smallest code point that a sequence of the given length may encode.
    function automatic logic [30:0] min_value(input logic [2:0] len);
        logic [30:0] v;
        unique case (len)
            3'd2:    v = 31'h80;
            3'd3:    v = 31'h800;
            3'd4:    v = 31'h10000;
            3'd5:    v = 31'h200000;
            3'd6:    v = 31'h4000000;
            default: v = 31'h0;
        endcase
        return v;
    endfunction

endpackage

[sv/utf8sd_step.sv]
module utf8sd_step (
    input  utf8sd_pkg::dec_state_t  state_in,
    input  logic [7:0]              in_byte,
    input  logic                    last_byte,
    input  logic [15:0]             out_capacity,
    output utf8sd_pkg::dec_state_t  state_out,
    output utf8sd_pkg::dec_result_t result,
    output logic                    result_valid
);

    logic [2:0]  lead_len;
    logic [2:0]  held_len;
    logic [30:0] accum_shift;
    logic [7:0]  lead_mask;
    logic [2:0]  pos_dec;
    logic [15:0] unit;
    logic        has;
    logic        err;
    utf8sd_pkg::dec_state_t nxt;

    assign lead_len    = utf8sd_pkg::seq_length(in_byte);
    assign held_len    = utf8sd_pkg::seq_length(state_in.lead_byte);
    assign accum_shift = {state_in.accum_value[24:0], in_byte[5:0]};
    assign lead_mask   = 8'h7F >> lead_len;
    assign pos_dec     = state_in.seq_position - 3'd1;

    always_comb begin
        nxt  = state_in;
        unit = 16'd0;
        has  = 1'b0;
        err  = 1'b0;
        if (!state_in.halted) begin
            if (state_in.seq_position == 3'd0) begin
                if (state_in.units_written >= out_capacity) begin
                    nxt.halted = 1'b1;
                end else if (lead_len == 3'd0) begin
                    err = 1'b1;
                end else if (lead_len == 3'd1) begin
                    unit = {8'd0, in_byte};
                    has  = 1'b1;
                end else if (last_byte) begin
                    // A multi-byte lead cannot start on the final byte.
                    err = 1'b1;
                end else begin
                    nxt.lead_byte    = in_byte;
                    nxt.accum_value  = {23'd0, in_byte & lead_mask};
                    nxt.seq_position = lead_len - 3'd1;
                end
            end else if (in_byte[7:6] != 2'b10) begin
                err = 1'b1;
            end else begin
                nxt.accum_value  = accum_shift;
                nxt.seq_position = pos_dec;
                if (pos_dec == 3'd0) begin
                    if (held_len < 3'd2 || accum_shift < utf8sd_pkg::min_value(held_len)) begin
                        err = 1'b1;
                    end else begin
                        unit = accum_shift[15:0];
                        has  = 1'b1;
                    end
                end else if (last_byte) begin
                    err = 1'b1;
                end
            end
        end
        if (err) begin
            nxt.halted       = 1'b1;
            nxt.seq_position = 3'd0;
        end
        if (has) begin
            nxt.units_written = state_in.units_written + 16'd1;
        end

        result.code_unit    = unit;
        result.has_unit     = has;
        result.decode_error = err;
        result.string_end   = last_byte;
        result.unit_count   = nxt.units_written;
        result_valid        = has | err | last_byte;

        // The final byte returns the per-string state to its reset values.
        if (last_byte) begin
            state_out = '0;
        end else begin
            state_out = nxt;
        end
    end

endmodule

[sv/utf8_string_decoder_unit.sv]
// UTF-8 string decoder.
// Input stream (s_*): one byte of a string per transfer in s_tdata, with
// s_tlast set on the final byte of the string.
// Output stream (m_*): one transfer per completed character, per decoding
// error and per string end. m_tdata carries the code unit (low 16 bits of
// the code point) and the running unit count; m_tuser flags a new unit and
// an error; m_tlast marks the result of the string's final byte.
// cfg_wr_en / cfg_wr_data set the maximum number of units per string; the user
// must write it only while the block is idle; the block does not enforce this.
// Each result is registered in the output stage, or in the skid register
// while the receiver stalls. Throughput: one byte per cycle while s_tready
// is high; a combinational step updates the per-string state per accepted byte.
// Reset (aresetn low, synchronous) clears the string state, empties the
// output stage and restores the capacity to 1024.
// When the receiver stalls, one more result is held in a skid register;
// s_tready drops only while that register is occupied.
module utf8_string_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] code_unit, [31:16] unit_count
    output logic [1:0]  m_tuser,   // [0] has_unit, [1] decode_error
    output logic        m_tlast    // string_end
);

    logic [15:0]             capacity_reg;
    utf8sd_pkg::dec_state_t  state_reg;
    utf8sd_pkg::dec_state_t  state_next;
    utf8sd_pkg::dec_result_t step_result;
    logic                    step_valid;
    utf8sd_pkg::dec_result_t out_reg;
    logic                    out_valid_reg;
    utf8sd_pkg::dec_result_t skid_reg;
    logic                    skid_valid_reg;
    logic                    in_fire;
    logic                    new_valid;
    logic                    out_free;

    utf8sd_step u_step (
        .state_in     (state_reg),
        .in_byte      (s_tdata),
        .last_byte    (s_tlast),
        .out_capacity (capacity_reg),
        .state_out    (state_next),
        .result       (step_result),
        .result_valid (step_valid)
    );

    assign s_tready  = ~skid_valid_reg;
    assign in_fire   = s_tvalid & s_tready;
    assign new_valid = in_fire & step_valid;
    assign out_free  = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= utf8sd_pkg::CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= new_valid;
            end
        end else if (new_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= step_result;
            end
        end
        if (new_valid && !(out_free && !skid_valid_reg)) begin
            skid_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.unit_count, out_reg.code_unit};
    assign m_tuser  = {out_reg.decode_error, out_reg.has_unit};
    assign m_tlast  = out_reg.string_end;

endmodule
